[rtl/noise_burst_generator_assert.svh]
// Assertion macros used by the noise burst generator top level.
`ifndef NOISE_BURST_GENERATOR_ASSERT_SVH
`define NOISE_BURST_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define NBG_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define NBG_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nbg_pkg.sv]
// Package with shared types and constants of the noise burst generator.
`default_nettype none
package nbg_pkg;

  localparam int SEED_W     = 32;
  localparam int FRAMES_W   = 20;
  localparam int GAIN_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Magnitude after gain is Q0.31 and always below 2^31.
  localparam int MAG_W      = 31;
  localparam int NOISE_W    = 16;
  localparam int DIVIDEND_W = MAG_W + FRAMES_W;
  localparam int DIV_CNT_W  = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MAG_W - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;

  localparam logic [SEED_W-1:0]   SEED_RST   = 32'd1;
  localparam logic [FRAMES_W-1:0] FRAMES_RST = 20'd3308;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd14418;

  localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;

  localparam logic [NOISE_W-1:0] NOISE_MID = 16'h8000;

  // Attack length floor(F*8/100) = floor(F*2/25), taken as F * 2*ceil(2^26/25) >> 26,
  // which is exact for every F below 2^20.
  localparam int ALEN_MUL_W  = 23;
  localparam int ALEN_SHIFT  = 26;
  localparam int ALEN_PROD_W = FRAMES_W + ALEN_MUL_W;
  localparam logic [ALEN_MUL_W-1:0] ALEN_MUL = 23'd5368710;

  typedef struct packed {
    logic load;
    logic lcg;
    logic mag;
    logic gain;
    logic amul;
    logic rmul;
    logic div_step;
    logic emit;
  } nbg_cmd_t;

  typedef struct packed {
    logic burst_done;
    logic attack;
    logic div_last;
  } nbg_stat_t;

endpackage
`default_nettype wire

[rtl/nbg_in_if.sv]
// Input channel: one beat per sample tick, carrying the restart flag.
`default_nettype none
interface nbg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface
`default_nettype wire

[rtl/nbg_out_if.sv]
// Output channel: one beat per sample with the last and idle flags.
`default_nettype none
interface nbg_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [nbg_pkg::SAMPLE_W-1:0]   sample;
  logic                                  last;
  logic                                  idle;

  modport source (output valid, output sample, output last, output idle, input ready);
  modport sink (input valid, input sample, input last, input idle, output ready);
endinterface
`default_nettype wire

[rtl/nbg_ctrl.sv]
// Controller state machine: sequences the datapath and owns the output valid.
`default_nettype none
module nbg_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_restart,
  output logic                in_ready,
  input  wire                 out_ready,
  output logic                out_valid,
  output nbg_pkg::nbg_cmd_t   cmd,
  input  nbg_pkg::nbg_stat_t  st
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LCG  = 9'b000000010,
    S_MAG  = 9'b000000100,
    S_GAIN = 9'b000001000,
    S_AMUL = 9'b000010000,
    S_ADIV = 9'b000100000,
    S_RMUL = 9'b001000000,
    S_RDIV = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          // A finished burst with no restart gives a silent beat at once.
          state_nxt = (st.burst_done && !in_restart) ? S_EMIT : S_LCG;
        end
      end
      S_LCG: begin
        cmd.lcg   = 1'b1;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = st.attack ? S_AMUL : S_RMUL;
      end
      S_AMUL: begin
        cmd.amul  = 1'b1;
        state_nxt = S_ADIV;
      end
      S_ADIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = S_RMUL;
      end
      S_RMUL: begin
        cmd.rmul  = 1'b1;
        state_nxt = S_RDIV;
      end
      S_RDIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/nbg_dp.sv]
// Datapath: configuration registers, LCG, gain, shared multiplier and radix-2 divider.
`default_nettype none
module nbg_dp #(
  parameter int FRAME_BITS = 20
) (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       cfg_we,
  input  wire  [nbg_pkg::CFG_IDX_W-1:0]             cfg_idx,
  input  wire  [nbg_pkg::CFG_DATA_W-1:0]            cfg_data,
  input  wire                                       in_restart,
  input  nbg_pkg::nbg_cmd_t                         cmd,
  output nbg_pkg::nbg_stat_t                        st,
  output logic signed [nbg_pkg::SAMPLE_W-1:0]       out_sample,
  output logic                                      out_last,
  output logic                                      out_idle
);

  localparam int FW = nbg_pkg::FRAMES_W;
  localparam int MW = nbg_pkg::MAG_W;
  localparam int DW = nbg_pkg::DIVIDEND_W;
  localparam int CW = (FRAME_BITS > FW) ? FRAME_BITS : FW;
  localparam logic [CW-1:0] FMASK = CW'({FRAME_BITS{1'b1}});

  // Configuration and burst state.
  logic [nbg_pkg::SEED_W-1:0] seed_r, seed_nxt;
  logic [FW-1:0]              burst_r, burst_nxt;
  logic [nbg_pkg::GAIN_W-1:0] gain_r, gain_nxt;
  logic [nbg_pkg::SEED_W-1:0] lcg_r, lcg_nxt;
  logic [FRAME_BITS-1:0]      idx_r, idx_nxt;
  logic                       done_r, done_nxt;

  // Per-sample working registers.
  logic [FW-1:0]                     frames_r, frames_nxt;
  logic [nbg_pkg::ALEN_PROD_W-1:0]   aprod_r, aprod_nxt;
  logic [FW-1:0]                     alen_r, alen_nxt;
  logic [nbg_pkg::NOISE_W-1:0]       mag_r, mag_nxt;
  logic                              neg_r, neg_nxt;
  logic [MW-1:0]                     m_r, m_nxt;
  logic [FW-1:0]                     rem_r, rem_nxt;
  logic [MW-1:0]                     dq_r, dq_nxt;
  logic [FW-1:0]                     dvs_r, dvs_nxt;
  logic [nbg_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic signed [nbg_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                              last_r, last_nxt;
  logic                              idle_r, idle_nxt;

  logic [CW-1:0]                 i_ext, frames_ext, alen_ext, burst_ext;
  logic [CW:0]                   i_inc;
  logic [FW-1:0]                 frames_eff, rel, mul_b;
  logic [DW-1:0]                 prod;
  logic [FW+1:0]                 diff;
  logic                          qbit, div_last, is_last;
  logic [nbg_pkg::NOISE_W-1:0]   raw;
  logic [2*nbg_pkg::GAIN_W-1:0]  gprod;
  logic [nbg_pkg::SAMPLE_W-1:0]  mag_out;
  logic [FW-1:0]                 alen_raw;

  assign i_ext      = CW'(idx_r);
  assign frames_ext = CW'(frames_r);
  assign alen_ext   = CW'(alen_r);
  assign burst_ext  = CW'(burst_r);
  assign i_inc      = {1'b0, i_ext} + {{CW{1'b0}}, 1'b1};

  // Effective length: saturate to the frame counter, and zero acts as one.
  always_comb begin
    frames_eff = (burst_ext > FMASK) ? FMASK[FW-1:0] : burst_r;
    if (frames_eff == '0) frames_eff = {{(FW-1){1'b0}}, 1'b1};
  end

  assign rel   = (frames_ext > i_ext) ? (frames_r - i_ext[FW-1:0]) : '0;
  // The attack index is only used while it lies below the attack length.
  assign mul_b = cmd.amul ? i_ext[FW-1:0] : rel;
  assign prod  = m_r * mul_b;

  // One restoring division step: the quotient is known to fit in MW bits.
  assign diff     = {1'b0, rem_r, dq_r[MW-1]} - {2'b00, dvs_r};
  assign qbit     = !diff[FW+1];
  assign div_last = (cnt_r == nbg_pkg::DIV_LAST);

  assign raw      = lcg_r[23:8];
  assign gprod    = mag_r * gain_r;
  assign mag_out  = {1'b0, m_r[MW-1:nbg_pkg::SAMPLE_W]};
  assign alen_raw = FW'(aprod_r[nbg_pkg::ALEN_PROD_W-1:nbg_pkg::ALEN_SHIFT]);
  assign is_last  = (i_inc >= {1'b0, frames_ext});

  assign st.burst_done = done_r;
  assign st.attack     = (i_ext < alen_ext);
  assign st.div_last   = div_last;

  always_comb begin
    seed_nxt   = seed_r;
    burst_nxt  = burst_r;
    gain_nxt   = gain_r;
    lcg_nxt    = lcg_r;
    idx_nxt    = idx_r;
    done_nxt   = done_r;
    frames_nxt = frames_r;
    aprod_nxt  = aprod_r;
    alen_nxt   = alen_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    m_nxt      = m_r;
    rem_nxt    = rem_r;
    dq_nxt     = dq_r;
    dvs_nxt    = dvs_r;
    cnt_nxt    = cnt_r;
    sample_nxt = sample_r;
    last_nxt   = last_r;
    idle_nxt   = idle_r;

    if (cfg_we) begin
      unique case (cfg_idx)
        nbg_pkg::CFG_SEED:   seed_nxt  = cfg_data;
        nbg_pkg::CFG_FRAMES: burst_nxt = cfg_data[FW-1:0];
        nbg_pkg::CFG_GAIN:   gain_nxt  = cfg_data[nbg_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end

    if (cmd.load) begin
      frames_nxt = frames_eff;
      if (in_restart) begin
        lcg_nxt  = (seed_r == '0) ? nbg_pkg::SEED_RST : seed_r;
        idx_nxt  = '0;
        done_nxt = 1'b0;
      end
    end

    if (cmd.lcg) begin
      lcg_nxt   = lcg_r * nbg_pkg::LCG_MUL + nbg_pkg::LCG_ADD;
      aprod_nxt = frames_r * nbg_pkg::ALEN_MUL;
    end

    if (cmd.mag) begin
      neg_nxt  = !raw[nbg_pkg::NOISE_W-1];
      mag_nxt  = raw[nbg_pkg::NOISE_W-1] ? (raw - nbg_pkg::NOISE_MID)
                                          : (nbg_pkg::NOISE_MID - raw);
      alen_nxt = (alen_raw == '0) ? {{(FW-1){1'b0}}, 1'b1} : alen_raw;
    end

    if (cmd.gain) m_nxt = gprod[MW-1:0];

    if (cmd.amul || cmd.rmul) begin
      rem_nxt = prod[DW-1:MW];
      dq_nxt  = prod[MW-1:0];
      dvs_nxt = cmd.amul ? alen_r : frames_r;
      cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      rem_nxt = qbit ? diff[FW-1:0] : {rem_r[FW-2:0], dq_r[MW-1]};
      dq_nxt  = {dq_r[MW-2:0], qbit};
      cnt_nxt = cnt_r + {{(nbg_pkg::DIV_CNT_W-1){1'b0}}, 1'b1};
      if (div_last) m_nxt = {dq_r[MW-2:0], qbit};
    end

    if (cmd.emit) begin
      if (done_r) begin
        sample_nxt = '0;
        last_nxt   = 1'b0;
        idle_nxt   = 1'b1;
      end else begin
        sample_nxt = neg_r ? signed'(~mag_out + 16'd1) : signed'(mag_out);
        last_nxt   = is_last;
        idle_nxt   = 1'b0;
        if (is_last) done_nxt = 1'b1;
        else idx_nxt = idx_r + {{(FRAME_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= nbg_pkg::SEED_RST;
      burst_r <= nbg_pkg::FRAMES_RST;
      gain_r  <= nbg_pkg::GAIN_RST;
      lcg_r   <= nbg_pkg::SEED_RST;
      idx_r   <= '0;
      done_r  <= 1'b1;
    end else begin
      seed_r  <= seed_nxt;
      burst_r <= burst_nxt;
      gain_r  <= gain_nxt;
      lcg_r   <= lcg_nxt;
      idx_r   <= idx_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frames_r <= frames_nxt;
    aprod_r  <= aprod_nxt;
    alen_r   <= alen_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    m_r      <= m_nxt;
    rem_r    <= rem_nxt;
    dq_r     <= dq_nxt;
    dvs_r    <= dvs_nxt;
    cnt_r    <= cnt_nxt;
    sample_r <= sample_nxt;
    last_r   <= last_nxt;
    idle_r   <= idle_nxt;
  end

  assign out_sample = sample_r;
  assign out_last   = last_r;
  assign out_idle   = idle_r;

endmodule
`default_nettype wire

[rtl/noise_burst_generator.sv]
// An accepted beat steps through LCG, magnitude, gain, attack multiply and divide (during the
// attack ramp only), release multiply and divide, and emit; a silent beat goes straight to emit.
// No new beat is taken until the last one is emitted, and emit waits while the output is held.
// The shared radix-2 divider takes 31 steps per division, two in the attack ramp, one after it.
// Reset: synchronous, active low; registers return to seed 1, length 3308, gain 14418,
// and the generator is idle with no burst active.
`default_nettype none
`include "noise_burst_generator_assert.svh"
module noise_burst_generator #(
  parameter int FRAME_BITS = 20
) (
  input  wire                               clk,
  input  wire                               rst_n,
  nbg_in_if.sink                            in_ch,
  nbg_out_if.source                         out_ch,
  input  wire                               cfg_we,
  input  wire  [nbg_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire  [nbg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  nbg_pkg::nbg_cmd_t  cmd;
  nbg_pkg::nbg_stat_t st;

  nbg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .cmd        (cmd),
    .st         (st)
  );

  nbg_dp #(
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_restart (in_ch.restart),
    .cmd        (cmd),
    .st         (st),
    .out_sample (out_ch.sample),
    .out_last   (out_ch.last),
    .out_idle   (out_ch.idle)
  );

  // A silent beat never carries a sample or the end-of-burst flag.
  `NBG_ASSERT_IMP(a_idle_silent, clk, rst_n, out_ch.valid && out_ch.idle, out_ch.sample == '0 && !out_ch.last, "idle beat carries data")
  // One beat at a time: the input closes as soon as a beat is taken.
  `NBG_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "input open while a beat is in work")
  // Every finished sample shows up as an output beat in the next cycle.
  `NBG_ASSERT_NXT(a_emit_valid, clk, rst_n, cmd.emit, out_ch.valid, "finished sample not presented")

endmodule
`default_nettype wire
